>>> rtl/core/qoi_pixel_encoder_unit_assert.svh
// Assertion macros for the QOI pixel encoder, empty when synthesized.
`ifndef QOI_PIXEL_ENCODER_UNIT_ASSERT_SVH
`define QOI_PIXEL_ENCODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// The condition must never hold.
`define QPE_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("qpe: forbidden condition seen");
// The consequent must hold in the same cycle as the antecedent.
`define QPE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qpe: implication failed");
// The consequent must hold in the cycle after the antecedent.
`define QPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qpe: next-cycle implication failed");
`else
`define QPE_ASSERT_NEVER(label, clk, rst, expr)
`define QPE_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define QPE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/qpe_pkg.sv
// Constants, chunk codes and the index hash of the QOI pixel encoder.
`default_nettype none

package qpe_pkg;

  localparam int unsigned IndexDepth = 64;
  localparam int unsigned IndexAw    = $clog2(IndexDepth);
  localparam int unsigned MaxBytes   = 6;

  localparam logic [31:0] OPAQUE_BLACK = 32'hFF00_0000;
  localparam logic [5:0]  RUN_MAX      = 6'd62;

  // Chunk tags.
  localparam logic [1:0] TAG_INDEX = 2'b00;
  localparam logic [1:0] TAG_DIFF  = 2'b01;
  localparam logic [1:0] TAG_LUMA  = 2'b10;
  localparam logic [1:0] TAG_RUN   = 2'b11;
  localparam logic [7:0] OP_RGB    = 8'hFE;
  localparam logic [7:0] OP_RGBA   = 8'hFF;

  // Index position: (3r + 5g + 7b + 11a) mod 64, only low bits matter.
  function automatic logic [IndexAw-1:0] qpe_hash(input logic [31:0] px);
    logic [IndexAw-1:0] r3, g5, b7, a11;
    r3  = px[IndexAw-1:0]    * IndexAw'(3);
    g5  = px[8+:IndexAw]     * IndexAw'(5);
    b7  = px[16+:IndexAw]    * IndexAw'(7);
    a11 = px[24+:IndexAw]    * IndexAw'(11);
    return r3 + g5 + b7 + a11;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/qoi_pixel_encoder_unit.sv
// QOI pixel encoder: pixel stream in, QOI chunk byte stream out.
`default_nettype none

`include "qoi_pixel_encoder_unit_assert.svh"

// Takes one straight-alpha RGBA pixel per item and emits the QOI chunk bytes
// it causes (run, index, diff, luma, RGB or RGBA; no header or end marker).
// The 64-entry index table lives in a 64 x 32 synchronous memory read when a
// pixel is accepted and written back when it leaves the encode stage, with
// forwarding when consecutive pixels hit the same entry; valid bits are
// flip-flops cleared by reset and by a first pixel, so no clearing pass is
// needed. An accepted pixel is registered in the encode stage and its chunk
// is loaded into the output buffer when that stage fires; the buffer drains
// one byte per cycle while m_tready is high. A pixel produces up to six bytes,
// and one that only extends a run produces none. The output byte register
// lets the next pixel be accepted while the previous chunk is still draining.
module qoi_pixel_encoder_unit import qpe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: alpha_mode.
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  // Pixel input.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // red [7:0], green [15:8], blue [23:16], alpha [31:24]
  input  wire logic        s_tuser,   // first_pixel [0]
  input  wire logic        s_tlast,   // last_pixel
  // Chunk byte output.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // out_byte [7:0]
  output logic             m_tlast    // last_byte
);

  // Configuration register.
  logic alpha_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_mode <= 1'b0;
    end else if (cfg_we) begin
      alpha_mode <= cfg_wdata;
    end
  end

  // Input pixel word, alpha forced opaque in three-channel mode.
  logic               s_accept;
  logic [31:0]        in_px;
  logic [IndexAw-1:0] in_hash;

  assign s_accept = s_tvalid && s_tready;
  assign in_px    = {alpha_mode ? s_tdata[31:24] : 8'hFF, s_tdata[23:0]};
  assign in_hash  = qpe_hash(in_px);

  // Encode stage registers.
  logic               s1_valid;
  logic [31:0]        s1_px;
  logic [IndexAw-1:0] s1_hash;
  logic               s1_first;
  logic               s1_last;
  logic               s1_fire;

  // Index table memory and forwarding of a same-edge write.
  logic [31:0]        index_mem [IndexDepth];
  logic [31:0]        mem_rd;
  logic               mem_we;
  logic               fwd_hit;
  logic [31:0]        fwd_data;
  logic [IndexDepth-1:0] index_valid;
  logic [IndexDepth-1:0] index_valid_next;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      index_mem[s1_hash] <= s1_px;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      mem_rd   <= index_mem[in_hash];
      fwd_hit  <= mem_we && (s1_hash == in_hash);
      fwd_data <= s1_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_px    <= in_px;
      s1_hash  <= in_hash;
      s1_first <= s_tuser;
      s1_last  <= s_tlast;
    end
  end

  // Encoder state.
  logic [31:0] prev_px;
  logic [5:0]  run;

  // Previous pixel and run as seen by this pixel after a first-pixel reset.
  logic [31:0] eff_prev;
  logic [5:0]  eff_run;
  logic [5:0]  run_inc;
  logic        px_eq;
  logic        valid_h;
  logic [31:0] stored;
  logic        idx_hit;
  logic        use_diffs;

  assign eff_prev  = s1_first ? OPAQUE_BLACK : prev_px;
  assign eff_run   = s1_first ? 6'd0 : run;
  assign run_inc   = eff_run + 6'd1;
  assign px_eq     = (s1_px == eff_prev);
  assign valid_h   = !s1_first && index_valid[s1_hash];
  assign stored    = valid_h ? (fwd_hit ? fwd_data : mem_rd) : 32'd0;
  assign idx_hit   = (stored == s1_px);
  assign use_diffs = !alpha_mode || (s1_px[31:24] == eff_prev[31:24]);

  // Channel differences, wrapped to signed 8 bits.
  logic [7:0]        dr, dg, db;
  logic signed [8:0] vr, vg, vb, vgr, vgb;
  logic              diff_ok, luma_ok;

  assign dr  = s1_px[7:0]   - eff_prev[7:0];
  assign dg  = s1_px[15:8]  - eff_prev[15:8];
  assign db  = s1_px[23:16] - eff_prev[23:16];
  assign vr  = {dr[7], dr};
  assign vg  = {dg[7], dg};
  assign vb  = {db[7], db};
  assign vgr = vr - vg;
  assign vgb = vb - vg;

  assign diff_ok = (vr >= -9'sd2) && (vr <= 9'sd1) && (vg >= -9'sd2) && (vg <= 9'sd1)
                && (vb >= -9'sd2) && (vb <= 9'sd1);
  assign luma_ok = (vgr >= -9'sd8) && (vgr <= 9'sd7) && (vg >= -9'sd32) && (vg <= 9'sd31)
                && (vgb >= -9'sd8) && (vgb <= 9'sd7);

  // Chunk assembly: optional run flush followed by this pixel's chunk.
  logic [7:0] chunk [MaxBytes];
  logic [2:0] chunk_n;
  logic [7:0] s1_bytes [MaxBytes];
  logic [2:0] s1_n;
  logic [5:0] run_next;
  logic       flush;

  always_comb begin
    for (int i = 0; i < MaxBytes; i++) begin
      chunk[i] = 8'd0;
    end
    chunk_n  = 3'd0;
    run_next = 6'd0;
    flush    = 1'b0;
    if (px_eq) begin
      // Equal pixel: extend the run, emit it when full or at the image end.
      if (run_inc >= RUN_MAX || s1_last) begin
        chunk[0] = {TAG_RUN, eff_run};
        chunk_n  = 3'd1;
      end else begin
        run_next = run_inc;
      end
    end else begin
      flush = (eff_run != 6'd0);
      if (idx_hit) begin
        chunk[0] = {TAG_INDEX, s1_hash};
        chunk_n  = 3'd1;
      end else if (!use_diffs) begin
        chunk[0] = OP_RGBA;
        chunk[1] = s1_px[7:0];
        chunk[2] = s1_px[15:8];
        chunk[3] = s1_px[23:16];
        chunk[4] = s1_px[31:24];
        chunk_n  = 3'd5;
      end else if (diff_ok) begin
        chunk[0] = {TAG_DIFF, dr[1:0] + 2'd2, dg[1:0] + 2'd2, db[1:0] + 2'd2};
        chunk_n  = 3'd1;
      end else if (luma_ok) begin
        chunk[0] = {TAG_LUMA, dg[5:0] + 6'd32};
        chunk[1] = {vgr[3:0] + 4'd8, vgb[3:0] + 4'd8};
        chunk_n  = 3'd2;
      end else begin
        chunk[0] = OP_RGB;
        chunk[1] = s1_px[7:0];
        chunk[2] = s1_px[15:8];
        chunk[3] = s1_px[23:16];
        chunk_n  = 3'd4;
      end
    end
    // Put the flushed run byte in front of the chunk.
    if (flush) begin
      s1_bytes[0] = {TAG_RUN, eff_run - 6'd1};
      for (int i = 1; i < MaxBytes; i++) begin
        s1_bytes[i] = chunk[i-1];
      end
      s1_n = chunk_n + 3'd1;
    end else begin
      for (int i = 0; i < MaxBytes; i++) begin
        s1_bytes[i] = chunk[i];
      end
      s1_n = chunk_n;
    end
  end

  // Output buffer holding one pixel's chunk bytes.
  logic [7:0] buf_bytes [MaxBytes];
  logic [2:0] buf_cnt;
  logic [2:0] buf_ptr;
  logic       buf_valid;
  logic       buf_take;
  logic       buf_done;
  logic       buf_free;

  assign m_tvalid = buf_valid;
  assign m_tdata  = buf_bytes[buf_ptr];
  assign m_tlast  = (buf_ptr == buf_cnt - 3'd1);
  assign buf_take = buf_valid && m_tready;
  assign buf_done = buf_take && m_tlast;
  assign buf_free = !buf_valid || buf_done;

  // The encode stage advances when its bytes have a place to go.
  assign s1_fire  = s1_valid && ((s1_n == 3'd0) || buf_free);
  assign s_tready = !s1_valid || s1_fire;
  assign mem_we   = s1_fire && !px_eq && !idx_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      buf_ptr   <= 3'd0;
      buf_cnt   <= 3'd0;
    end else if (s1_fire && (s1_n != 3'd0)) begin
      buf_valid <= 1'b1;
      buf_ptr   <= 3'd0;
      buf_cnt   <= s1_n;
    end else if (buf_done) begin
      buf_valid <= 1'b0;
    end else if (buf_take) begin
      buf_ptr <= buf_ptr + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && (s1_n != 3'd0)) begin
      buf_bytes <= s1_bytes;
    end
  end

  // Valid bits after this pixel: cleared by a first pixel, then the written entry set.
  always_comb begin
    index_valid_next = s1_first ? '0 : index_valid;
    if (mem_we) begin
      index_valid_next[s1_hash] = 1'b1;
    end
  end

  // State update when a pixel leaves the encode stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_px     <= OPAQUE_BLACK;
      run         <= 6'd0;
      index_valid <= '0;
    end else if (s1_fire) begin
      prev_px     <= s1_px;
      run         <= run_next;
      index_valid <= index_valid_next;
    end
  end

  // Checks on run bound, buffer pointer, handoff and index bookkeeping.
  `QPE_ASSERT_NEVER(a_run_bound, clk, rst, run >= RUN_MAX)
  `QPE_ASSERT_IMPLIES(a_ptr_in_range, clk, rst, buf_valid, buf_ptr < buf_cnt)
  `QPE_ASSERT_NEXT(a_chunk_handoff, clk, rst, buf_done, !buf_valid || buf_ptr == 3'd0)
  `QPE_ASSERT_NEXT(a_write_marks_valid, clk, rst, mem_we, index_valid[$past(s1_hash)])

endmodule

`default_nettype wire
